>>> hw/rtl/nce_pkg.sv
// shared types and constants for the neighbor contrast energy block
package nce_pkg;

	localparam int PIX_W     = 8;
	localparam int DIM_W     = 13;
	localparam int SUM_W     = 43;
	localparam int PSUM_W    = 42;
	localparam int MEAN_W    = 24;
	localparam int PCNT_W    = 26;
	localparam int CFG_IDX_W = 2;
	localparam int SQ_W      = 2 * PIX_W + 1;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = CFG_IDX_W'(1);

	localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(2);
	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(2);

	typedef struct packed {
		logic run;
		logic done;
	} div_stat_t;

endpackage

>>> hw/rtl/nce_line_mem.sv
// one-line pixel store, read-before-write, registered read data
module nce_line_mem import nce_pkg::*; #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic             clk,
	input  logic             en,
	input  logic [AW-1:0]    addr,
	input  logic [PIX_W-1:0] wdata,
	output logic [PIX_W-1:0] rdata
);

	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] rd_q;

	// old contents come out while the new pixel goes in
	always_ff @(posedge clk) begin
		if (en) begin
			rd_q      <= mem[addr];
			mem[addr] <= wdata;
		end
	end

	assign rdata = rd_q;

endmodule

>>> hw/rtl/nce_div.sv
// restoring divider, one quotient bit per cycle
module nce_div import nce_pkg::*; #(
	parameter int NUM_W = 51,
	parameter int DEN_W = 28
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic             take,
	output div_stat_t        stat,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;

	logic [DEN_W:0]   rem_sh;
	logic             ge;
	logic [DEN_W-1:0] rem_nx;

	always_comb begin
		rem_sh = {rem_q, num_q[NUM_W-1]};
		ge     = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						cnt_q   <= CNT_W'(NUM_W);
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// numerator register shifts out dividend bits and takes in quotient bits
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (state_q == ST_RUN) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign stat.run  = state_q != ST_IDLE;
	assign stat.done = state_q == ST_DONE;
	assign quot      = num_q;

endmodule

>>> hw/rtl/neighbor_contrast_energy.sv
// top level: raster pixel stream in, per-frame contrast sum and mean out
// throughput: one pixel per clock; the last pixel of a frame waits while the previous
// frame's last pixel is still in stage 1 or 2, its divide still runs or its result is not yet taken
// result: the frame sum passes stage 1, stage 2, the one-bit-per-cycle divider
// and then the result register
// reset: both dimension registers to 2, counters and sum to zero; line memory is not cleared
module neighbor_contrast_energy import nce_pkg::*; #(
	parameter int MAX_COLS  = 4096,
	parameter int MAX_ROWS  = 4096,
	parameter int FRAC_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 pixel_valid,
	output logic                 pixel_ready,
	input  logic [PIX_W-1:0]     pixel,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [PSUM_W-1:0]    pair_sum,
	output logic [MEAN_W-1:0]    contrast_q8,
	output logic [PCNT_W-1:0]    pair_count
);

	localparam int CW    = $clog2(MAX_COLS);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CEW   = $clog2(MAX_COLS + 1);
	localparam int REW   = $clog2(MAX_ROWS + 1);
	localparam int PW    = REW + CEW;
	localparam int CNT_W = PW + 2;
	localparam int NUM_W = SUM_W + FRAC_BITS;

	logic [DIM_W-1:0] frame_rows_q;
	logic [DIM_W-1:0] frame_cols_q;
	logic [REW-1:0]   rows_eff;
	logic [CEW-1:0]   cols_eff;
	logic [PW-1:0]    prod_q;
	logic [CNT_W-1:0] cnt_q;

	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic [PIX_W-1:0] left_q;
	logic             last_col;
	logic             last_row;
	logic             frame_end;
	logic             px_acc;
	logic             restart;

	logic             vld_s1;
	logic             last_s1;
	logic             has_left_s1;
	logic             has_up_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [PIX_W-1:0] left_s1;
	logic [PIX_W-1:0] up_pix;

	logic [PIX_W-1:0]   dl;
	logic [PIX_W-1:0]   du;
	logic [2*PIX_W-1:0] sql;
	logic [2*PIX_W-1:0] squ;

	logic            vld_s2;
	logic            last_s2;
	logic [SQ_W-1:0] sq_s2;

	logic [SUM_W-1:0]  acc_q;
	logic [SUM_W-1:0]  acc_nx;
	logic              div_start;
	logic              take;
	div_stat_t         div_stat;
	logic [NUM_W-1:0]  quot;
	logic [MEAN_W-1:0] mean_sat;

	logic [PSUM_W-1:0] res_sum_q;
	logic [CNT_W-1:0]  res_cnt_q;
	logic              result_valid_q;
	logic [PSUM_W-1:0] pair_sum_q;
	logic [MEAN_W-1:0] contrast_q;
	logic [PCNT_W-1:0] pair_count_q;

	// configuration
	assign cfg_ready = 1'b1;
	assign restart   = cfg_valid && cfg_ready &&
		(cfg_index == REG_FRAME_ROWS || cfg_index == REG_FRAME_COLS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rows_q <= DIM_RESET;
			frame_cols_q <= DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_FRAME_ROWS) begin
				frame_rows_q <= cfg_data;
			end
			if (cfg_index == REG_FRAME_COLS) begin
				frame_cols_q <= cfg_data;
			end
		end
	end

	always_comb begin
		if (frame_rows_q < DIM_MIN) begin
			rows_eff = REW'(DIM_MIN);
		end else if (int'(frame_rows_q) > MAX_ROWS) begin
			rows_eff = REW'(MAX_ROWS);
		end else begin
			rows_eff = REW'(frame_rows_q);
		end
		if (frame_cols_q < DIM_MIN) begin
			cols_eff = CEW'(DIM_MIN);
		end else if (int'(frame_cols_q) > MAX_COLS) begin
			cols_eff = CEW'(MAX_COLS);
		end else begin
			cols_eff = CEW'(frame_cols_q);
		end
	end

	// pair count 4*r*c - 2*r - 2*c, registered through prod_q and then cnt_q after a register write
	always_ff @(posedge clk) begin
		prod_q <= PW'(rows_eff) * PW'(cols_eff);
		cnt_q  <= {prod_q, 2'b00} - CNT_W'({rows_eff, 1'b0}) - CNT_W'({cols_eff, 1'b0});
	end

	// raster position
	assign last_col  = col_q == CW'(cols_eff - 1'b1);
	assign last_row  = row_q == RW'(rows_eff - 1'b1);
	assign frame_end = last_col && last_row;

	// a frame's last item waits until the divider can take its sum
	assign pixel_ready = !frame_end ||
		!((vld_s1 && last_s1) || (vld_s2 && last_s2) || div_stat.run);
	assign px_acc = pixel_valid && pixel_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (px_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (px_acc) begin
			left_q <= pixel;
		end
	end

	nce_line_mem #(
		.DEPTH(MAX_COLS),
		.AW   (CW)
	) u_line (
		.clk  (clk),
		.en   (px_acc),
		.addr (col_q),
		.wdata(pixel),
		.rdata(up_pix)
	);

	// stage 1: pixel, left neighbor and upper neighbor side by side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= px_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (px_acc) begin
			pix_s1      <= pixel;
			left_s1     <= left_q;
			has_left_s1 <= col_q != '0;
			has_up_s1   <= row_q != '0;
			last_s1     <= frame_end;
		end
	end

	always_comb begin
		dl  = (pix_s1 >= left_s1) ? pix_s1 - left_s1 : left_s1 - pix_s1;
		du  = (pix_s1 >= up_pix) ? pix_s1 - up_pix : up_pix - pix_s1;
		sql = (2*PIX_W)'(dl) * (2*PIX_W)'(dl);
		squ = (2*PIX_W)'(du) * (2*PIX_W)'(du);
	end

	// stage 2: squared differences of the present neighbors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			sq_s2   <= (has_left_s1 ? SQ_W'(sql) : '0) + (has_up_s1 ? SQ_W'(squ) : '0);
			last_s2 <= last_s1;
		end
	end

	// accumulate; each pair counts once per direction, hence the doubling
	assign acc_nx    = acc_q + SUM_W'({sq_s2, 1'b0});
	assign div_start = vld_s2 && last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (restart) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= last_s2 ? '0 : acc_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			res_sum_q <= acc_nx[PSUM_W-1:0];
			res_cnt_q <= cnt_q;
		end
	end

	nce_div #(
		.NUM_W(NUM_W),
		.DEN_W(CNT_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (NUM_W'(acc_nx) << FRAC_BITS),
		.den   (cnt_q),
		.take  (take),
		.stat  (div_stat),
		.quot  (quot)
	);

	assign mean_sat = (|quot[NUM_W-1:MEAN_W]) ? '1 : quot[MEAN_W-1:0];

	// result register
	assign take = div_stat.done && (!result_valid_q || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (take) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pair_sum_q   <= res_sum_q;
			contrast_q   <= mean_sat;
			pair_count_q <= PCNT_W'(res_cnt_q);
		end
	end

	assign result_valid = result_valid_q;
	assign pair_sum     = pair_sum_q;
	assign contrast_q8  = contrast_q;
	assign pair_count   = pair_count_q;

	a_div_free_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.run)
		else $error("divider started while busy");

	a_one_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		!(vld_s1 && last_s1 && vld_s2 && last_s2))
		else $error("two frame ends in flight");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		CEW'(col_q) < cols_eff)
		else $error("column counter past row end");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		REW'(row_q) < rows_eff)
		else $error("row counter past frame end");

	a_take_shows: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> result_valid_q && !div_stat.done)
		else $error("divider result not moved to output");

endmodule
